### rtl/tfz_pkg.sv
// ----------------------------------------------------------------------------
// tfz_pkg
// Types and constants shared by the triangle fragment z-buffer MSAA unit.
// ----------------------------------------------------------------------------
package tfz_pkg;

  localparam int Z_W    = 24;  // depth and color width
  localparam int XW     = 21;  // scaled vertex coordinate, signed
  localparam int CW     = 20;  // scaled sample base coordinate, unsigned
  localparam int MW     = 25;  // multiplier operand, signed
  localparam int PRD_W  = 2 * MW;
  localparam int E_W    = 44;  // edge value, signed
  localparam int W_W    = 43;  // edge magnitude
  localparam int WLO_W  = 22;  // low half of a weight
  localparam int NUM_W  = 70;  // weighted depth sum
  localparam int D_W    = 46;  // weight sum
  localparam int Q_W    = 24;  // quotient bits
  localparam int N_W    = 4;   // grid size
  localparam int C_W    = 7;   // covered sample count
  localparam int ADDR_W = 24;  // pixel index
  localparam int FA_W   = 20;  // frame address output

  localparam logic [Z_W-1:0] FAR_DEPTH = '1;

  typedef struct packed {
    logic signed [15:0] vert0_x;
    logic signed [15:0] vert0_y;
    logic [23:0]        vert0_depth;
    logic signed [15:0] vert1_x;
    logic signed [15:0] vert1_y;
    logic [23:0]        vert1_depth;
    logic signed [15:0] vert2_x;
    logic signed [15:0] vert2_y;
    logic [23:0]        vert2_depth;
    logic [23:0]        tri_color;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
  } tfz_in_t;

  typedef struct packed {
    logic [19:0] frame_address;
    logic [23:0] pixel_color;
    logic [23:0] pixel_depth;
  } tfz_out_t;

  typedef struct packed {
    logic [N_W-1:0]         n;
    logic [2:0][XW-1:0]     vx;
    logic [2:0][XW-1:0]     vy;
    logic [2:0][Z_W-1:0]    vz;
    logic [Z_W-1:0]         color;
    logic [CW-1:0]          sx0;
    logic [CW-1:0]          sy0;
    logic [ADDR_W-1:0]      addr;
  } tfz_job_t;

endpackage

### rtl/triangle_fragment_zbuffer_msaa_unit.sv
// ----------------------------------------------------------------------------
// triangle_fragment_zbuffer_msaa_unit
// Fragment coverage, depth interpolation and z-buffer test with an n by n
// sample grid per pixel.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall/in_data) carry three vertices, a flat color
// and a pixel position. A beat that hits a pixel nearer than the stored depth
// gives one result beat (out_valid/out_stall/out_data) with the frame address,
// the color scaled by coverage and the new depth; other beats give nothing.
// The grid size is written through cfg_write_en/cfg_write_data; the user must
// do so only while idle, the block does not enforce it. The front part takes
// beats into a two-entry job queue; the back part works on one job at a time:
//   edge values for each sample on the multiplier, then for a covered sample
//   the weighted depth sum and a divide; then a depth store read and compare
//   and three divides for the color channels.
// The back part's shared divider sets the rate of covered pixels.
// After reset the depth store is swept to the farthest depth, one entry per
// cycle; in_stall is high meanwhile.
// A stalled result holds in the output register; the back part waits on it
// and the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module triangle_fragment_zbuffer_msaa_unit #(
  parameter int SCREEN_WIDTH         = 1024,
  parameter int SCREEN_HEIGHT        = 1024,
  parameter int MAX_SAMPLES_PER_AXIS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  tfz_pkg::tfz_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tfz_pkg::tfz_out_t out_data
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_not_empty;
  logic              clearing;
  tfz_pkg::tfz_job_t q_in;
  tfz_pkg::tfz_job_t q_out;

  tfz_front #(
    .SCREEN_WIDTH         (SCREEN_WIDTH),
    .SCREEN_HEIGHT        (SCREEN_HEIGHT),
    .MAX_SAMPLES_PER_AXIS (MAX_SAMPLES_PER_AXIS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .hold           (clearing),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  tfz_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  tfz_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job_data  (q_out),
    .job_pop   (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/tfz_ram.sv
// ----------------------------------------------------------------------------
// tfz_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tfz_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tfz_div.sv
// ----------------------------------------------------------------------------
// tfz_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// Q_W bits, so the upper part of the dividend is below the divisor.
// ----------------------------------------------------------------------------
module tfz_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tfz_pkg::NUM_W-1:0] num,
  input  logic [tfz_pkg::D_W-1:0]   den,
  output logic                      done,
  output logic [tfz_pkg::Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(tfz_pkg::Q_W + 1);

  logic [tfz_pkg::D_W-1:0] rem_r;
  logic [tfz_pkg::Q_W-1:0] low_r;
  logic [tfz_pkg::D_W-1:0] den_r;
  logic [tfz_pkg::Q_W-1:0] quot_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [tfz_pkg::D_W:0]   trial;
  logic [tfz_pkg::D_W:0]   diff;
  logic                    ge;

  always_comb begin
    trial = {rem_r, low_r[tfz_pkg::Q_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(tfz_pkg::Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[tfz_pkg::NUM_W-1:tfz_pkg::Q_W];
      low_r <= num[tfz_pkg::Q_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[tfz_pkg::D_W-1:0] : trial[tfz_pkg::D_W-1:0];
      low_r  <= {low_r[tfz_pkg::Q_W-2:0], 1'b0};
      quot_r <= {quot_r[tfz_pkg::Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### rtl/tfz_fifo.sv
// ----------------------------------------------------------------------------
// tfz_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module tfz_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tfz_pkg::tfz_job_t push_data,
  output logic              full,
  input  logic              pop,
  output tfz_pkg::tfz_job_t pop_data,
  output logic              not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tfz_pkg::tfz_job_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [PW:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = cnt_r == (PW + 1)'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

endmodule

### rtl/tfz_front.sv
// ----------------------------------------------------------------------------
// tfz_front
// Takes fragment beats, drops off-screen pixels, scales the vertices to the
// sample grid and queues a job for the back part. Holds the grid register.
// ----------------------------------------------------------------------------
module tfz_front #(
  parameter int SCREEN_WIDTH         = 1024,
  parameter int SCREEN_HEIGHT        = 1024,
  parameter int MAX_SAMPLES_PER_AXIS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  tfz_pkg::tfz_in_t  in_data,
  input  logic              hold,
  input  logic              q_full,
  output logic              q_push,
  output tfz_pkg::tfz_job_t q_data
);

  logic [2:0]                spa_r;
  logic [tfz_pkg::N_W-1:0]   n;
  logic [tfz_pkg::N_W:0]     s2;
  logic                      on_screen;
  logic [tfz_pkg::CW-1:0]    spx;
  logic [tfz_pkg::CW-1:0]    spy;
  logic [tfz_pkg::XW-1:0]    s2x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spa_r <= 3'd1;
    end else if (cfg_write_en) begin
      spa_r <= cfg_write_data;
    end
  end

  always_comb begin
    if (spa_r == 3'd0) begin
      n = tfz_pkg::N_W'(1);
    end else if (32'(spa_r) > MAX_SAMPLES_PER_AXIS) begin
      n = tfz_pkg::N_W'(MAX_SAMPLES_PER_AXIS);
    end else begin
      n = tfz_pkg::N_W'(spa_r);
    end
    s2  = {n, 1'b0};
    s2x = tfz_pkg::XW'(s2);
    on_screen = (32'(in_data.pixel_x) < SCREEN_WIDTH) &&
                (32'(in_data.pixel_y) < SCREEN_HEIGHT);
    spx = tfz_pkg::CW'(s2) * tfz_pkg::CW'(in_data.pixel_x);
    spy = tfz_pkg::CW'(s2) * tfz_pkg::CW'(in_data.pixel_y);

    q_data.n     = n;
    // vertices in units of 1/(32n) pixel, low bits of the product are exact
    q_data.vx[0] = tfz_pkg::XW'($signed(in_data.vert0_x)) * s2x;
    q_data.vy[0] = tfz_pkg::XW'($signed(in_data.vert0_y)) * s2x;
    q_data.vx[1] = tfz_pkg::XW'($signed(in_data.vert1_x)) * s2x;
    q_data.vy[1] = tfz_pkg::XW'($signed(in_data.vert1_y)) * s2x;
    q_data.vx[2] = tfz_pkg::XW'($signed(in_data.vert2_x)) * s2x;
    q_data.vy[2] = tfz_pkg::XW'($signed(in_data.vert2_y)) * s2x;
    q_data.vz[0] = in_data.vert0_depth;
    q_data.vz[1] = in_data.vert1_depth;
    q_data.vz[2] = in_data.vert2_depth;
    q_data.color = in_data.tri_color;
    q_data.sx0   = (spx + 1'b1) << 4;
    q_data.sy0   = (spy + 1'b1) << 4;
    q_data.addr  = tfz_pkg::ADDR_W'((SCREEN_HEIGHT - 1 - int'(in_data.pixel_y)) * SCREEN_WIDTH
                                    + int'(in_data.pixel_x));
  end

  assign in_stall = hold || q_full;
  assign q_push   = in_valid && !in_stall && on_screen;

endmodule

### rtl/tfz_back.sv
// ----------------------------------------------------------------------------
// tfz_back
// Walks the sample grid of one job: edge values and weighted depth on one
// shared multiplier, a shared divider for depth and coverage scaling, then
// the depth store test and the result register.
// ----------------------------------------------------------------------------
module tfz_back #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  tfz_pkg::tfz_job_t job_data,
  output logic              job_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output tfz_pkg::tfz_out_t out_data
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] STEP_EDGE_LAST = 4'd5;
  localparam logic [3:0] STEP_CHECK     = 4'd7;
  localparam logic [3:0] STEP_W_LAST    = 4'd12;
  localparam logic [3:0] STEP_DIV       = 4'd14;
  localparam logic [3:0] OP_W_FIRST     = 4'd6;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SAMPLE, ST_DIV, ST_READ, ST_CMP, ST_CSTART, ST_CWAIT
  } state_t;

  typedef logic signed [tfz_pkg::MW-1:0]    op_t;
  typedef logic signed [tfz_pkg::E_W-1:0]   edge_t;
  typedef logic [tfz_pkg::W_W-1:0]          wgt_t;

  state_t                     state_r, state_nxt;
  tfz_pkg::tfz_job_t          job_r, job_nxt;
  logic [tfz_pkg::N_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [3:0]                 step_r, step_nxt;
  edge_t                      e_r [3];
  edge_t                      e_nxt [3];
  logic signed [tfz_pkg::PRD_W-1:0] prod_r, prod_nxt;
  logic [3:0]                 pop_r, pop_nxt;
  logic                       pv_r, pv_nxt;
  logic [tfz_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic [tfz_pkg::D_W-1:0]    d_r, d_nxt;
  logic [tfz_pkg::Z_W-1:0]    best_r, best_nxt;
  logic [tfz_pkg::C_W-1:0]    count_r, count_nxt;
  logic [1:0]                 chan_r, chan_nxt;
  logic [tfz_pkg::Z_W-1:0]    color_r, color_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tfz_pkg::tfz_out_t          out_data_r, out_data_nxt;

  logic                       div_start;
  logic [tfz_pkg::NUM_W-1:0]  div_num;
  logic [tfz_pkg::D_W-1:0]    div_den;
  logic                       div_done;
  logic [tfz_pkg::Q_W-1:0]    div_quot;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tfz_pkg::Z_W-1:0]    ram_wdata;
  logic [tfz_pkg::Z_W-1:0]    ram_rdata;

  op_t                        sx, sy, xa, ya, xb, yb, op_a, op_b;
  wgt_t                       w0, w1, w2, wsel;
  logic [tfz_pkg::Z_W-1:0]    zsel;
  logic [3:0]                 wt;
  logic                       covered;
  logic                       issue;
  logic                       last_j, last_s;
  logic [tfz_pkg::N_W-1:0]    n_m1;
  logic [7:0]                 chan_val;
  logic [tfz_pkg::C_W-1:0]    count_inc;

  tfz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  tfz_ram #(
    .WIDTH (tfz_pkg::Z_W),
    .DEPTH (DEPTH)
  ) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (job_r.addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // operand selection for the shared multiplier
  always_comb begin
    sx = $signed(tfz_pkg::MW'(job_r.sx0)) + $signed(tfz_pkg::MW'({i_r, 5'b0}));
    sy = $signed(tfz_pkg::MW'(job_r.sy0)) + $signed(tfz_pkg::MW'({j_r, 5'b0}));
    case (step_r[2:1])
      2'd0: begin
        xa = tfz_pkg::MW'($signed(job_r.vx[0])); ya = tfz_pkg::MW'($signed(job_r.vy[0]));
        xb = tfz_pkg::MW'($signed(job_r.vx[1])); yb = tfz_pkg::MW'($signed(job_r.vy[1]));
      end
      2'd1: begin
        xa = tfz_pkg::MW'($signed(job_r.vx[1])); ya = tfz_pkg::MW'($signed(job_r.vy[1]));
        xb = tfz_pkg::MW'($signed(job_r.vx[2])); yb = tfz_pkg::MW'($signed(job_r.vy[2]));
      end
      default: begin
        xa = tfz_pkg::MW'($signed(job_r.vx[2])); ya = tfz_pkg::MW'($signed(job_r.vy[2]));
        xb = tfz_pkg::MW'($signed(job_r.vx[0])); yb = tfz_pkg::MW'($signed(job_r.vy[0]));
      end
    endcase

    // weight of vertex k is the magnitude of the edge opposite it
    w0 = wgt_t'(e_r[1] < 0 ? -e_r[1] : e_r[1]);
    w1 = wgt_t'(e_r[2] < 0 ? -e_r[2] : e_r[2]);
    w2 = wgt_t'(e_r[0] < 0 ? -e_r[0] : e_r[0]);
    wt = step_r - STEP_CHECK;
    case (wt[2:1])
      2'd0:    begin wsel = w0; zsel = job_r.vz[0]; end
      2'd1:    begin wsel = w1; zsel = job_r.vz[1]; end
      default: begin wsel = w2; zsel = job_r.vz[2]; end
    endcase

    if (step_r <= STEP_EDGE_LAST) begin
      op_a = step_r[0] ? (yb - ya) : (xb - xa);
      op_b = step_r[0] ? (sx - xa) : (sy - ya);
    end else begin
      op_a = wt[0] ? $signed(tfz_pkg::MW'(wsel[tfz_pkg::W_W-1:tfz_pkg::WLO_W]))
                   : $signed(tfz_pkg::MW'(wsel[tfz_pkg::WLO_W-1:0]));
      op_b = $signed(tfz_pkg::MW'(zsel));
    end

    covered = (e_r[0] > 0 && e_r[1] > 0 && e_r[2] > 0) ||
              (e_r[0] < 0 && e_r[1] < 0 && e_r[2] < 0);

    n_m1   = job_r.n - 1'b1;
    last_j = j_r == n_m1;
    last_s = last_j && (i_r == n_m1);

    case (chan_r)
      2'd0:    chan_val = job_r.color[23:16];
      2'd1:    chan_val = job_r.color[15:8];
      default: chan_val = job_r.color[7:0];
    endcase
    count_inc = count_r + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    step_nxt      = step_r;
    e_nxt         = e_r;
    prod_nxt      = prod_r;
    pop_nxt       = pop_r;
    pv_nxt        = 1'b0;
    num_nxt       = num_r;
    d_nxt         = d_r;
    best_nxt      = best_r;
    count_nxt     = count_r;
    chan_nxt      = chan_r;
    color_nxt     = color_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    job_pop       = 1'b0;
    div_start     = 1'b0;
    div_num       = num_r;
    div_den       = d_r;
    ram_we        = 1'b0;
    ram_waddr     = job_r.addr[AW-1:0];
    ram_wdata     = best_r;
    issue         = 1'b0;

    // fold in the product issued last cycle
    if (pv_r) begin
      if (pop_r < OP_W_FIRST) begin
        case (pop_r[2:1])
          2'd0:    e_nxt[0] = pop_r[0] ? e_r[0] - prod_r[tfz_pkg::E_W-1:0]
                                       : prod_r[tfz_pkg::E_W-1:0];
          2'd1:    e_nxt[1] = pop_r[0] ? e_r[1] - prod_r[tfz_pkg::E_W-1:0]
                                       : prod_r[tfz_pkg::E_W-1:0];
          default: e_nxt[2] = pop_r[0] ? e_r[2] - prod_r[tfz_pkg::E_W-1:0]
                                       : prod_r[tfz_pkg::E_W-1:0];
        endcase
      end else if (pop_r[0]) begin
        num_nxt = num_r + (tfz_pkg::NUM_W'(prod_r[tfz_pkg::PRD_W-3:0]) << tfz_pkg::WLO_W);
      end else begin
        num_nxt = num_r + tfz_pkg::NUM_W'(prod_r[tfz_pkg::PRD_W-3:0]);
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = tfz_pkg::FAR_DEPTH;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job_data;
          i_nxt     = '0;
          j_nxt     = '0;
          step_nxt  = '0;
          best_nxt  = tfz_pkg::FAR_DEPTH;
          count_nxt = '0;
          state_nxt = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        step_nxt = step_r + 1'b1;
        if (step_r <= STEP_EDGE_LAST) begin
          issue   = 1'b1;
          pop_nxt = step_r;
        end else if (step_r == STEP_CHECK) begin
          if (covered) begin
            issue   = 1'b1;
            pop_nxt = step_r - 1'b1;
            num_nxt = '0;
            d_nxt   = tfz_pkg::D_W'(w0) + tfz_pkg::D_W'(w1) + tfz_pkg::D_W'(w2);
          end else begin
            step_nxt = '0;
            if (last_s) begin
              state_nxt = (count_r == '0) ? ST_IDLE : ST_READ;
            end else begin
              i_nxt = last_j ? i_r + 1'b1 : i_r;
              j_nxt = last_j ? '0 : j_r + 1'b1;
            end
          end
        end else if (step_r > STEP_CHECK && step_r <= STEP_W_LAST) begin
          issue   = 1'b1;
          pop_nxt = step_r - 1'b1;
        end else if (step_r == STEP_DIV) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          count_nxt = count_inc;
          if (div_quot < best_r) begin
            best_nxt = div_quot;
          end
          step_nxt = '0;
          if (last_s) begin
            state_nxt = ST_READ;
          end else begin
            i_nxt     = last_j ? i_r + 1'b1 : i_r;
            j_nxt     = last_j ? '0 : j_r + 1'b1;
            state_nxt = ST_SAMPLE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (best_r < ram_rdata) begin
          ram_we    = 1'b1;
          chan_nxt  = '0;
          state_nxt = ST_CSTART;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CSTART: begin
        // channel * covered / n^2, on the same divider
        div_start = 1'b1;
        div_num   = tfz_pkg::NUM_W'(chan_val) * tfz_pkg::NUM_W'(count_r);
        div_den   = tfz_pkg::D_W'(job_r.n) * tfz_pkg::D_W'(job_r.n);
        state_nxt = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (div_done) begin
          case (chan_r)
            2'd0:    color_nxt[23:16] = div_quot[7:0];
            2'd1:    color_nxt[15:8]  = div_quot[7:0];
            default: color_nxt[7:0]   = div_quot[7:0];
          endcase
          if (chan_r == 2'd2) begin
            state_nxt = ST_CSTART;
            if (!out_valid_r || !out_stall) begin
              out_valid_nxt              = 1'b1;
              out_data_nxt.frame_address = job_r.addr[tfz_pkg::FA_W-1:0];
              out_data_nxt.pixel_color   = {color_r[23:8], div_quot[7:0]};
              out_data_nxt.pixel_depth   = best_r;
              state_nxt                  = ST_IDLE;
            end else begin
              // result register still full, retry the last channel
              chan_nxt = chan_r;
            end
          end else begin
            chan_nxt  = chan_r + 1'b1;
            state_nxt = ST_CSTART;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (issue) begin
      pv_nxt   = 1'b1;
      prod_nxt = op_a * op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    step_r     <= step_nxt;
    e_r        <= e_nxt;
    prod_r     <= prod_nxt;
    pop_r      <= pop_nxt;
    num_r      <= num_nxt;
    d_r        <= d_nxt;
    best_r     <= best_nxt;
    count_r    <= count_nxt;
    chan_r     <= chan_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
  end

  assign clearing  = state_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### bench/tb_triangle_fragment_zbuffer_msaa_unit.sv
// ----------------------------------------------------------------------------
// tb_triangle_fragment_zbuffer_msaa_unit
// Self-checking bench for the fragment coverage / z-buffer unit: directed
// corner fragments, then random fragments, many around a small set of pixels,
// under several grid sizes, with random idling on both channels and one long
// result hold-off. Results are compared against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_triangle_fragment_zbuffer_msaa_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W = 1024;
  localparam int SCR_H = 1024;
  localparam int MAX_N = 4;
  localparam int DRAIN_CYCLES = 4000;
  localparam longint CYCLE_LIMIT = 8000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [2:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  tfz_pkg::tfz_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tfz_pkg::tfz_out_t out_data;

  int err_count = 0;
  longint cycle_count = 0;
  bit idle_on = 1'b1;
  bit hold_out = 1'b0;

  // bench copies of the grid size and the depth store
  logic [2:0] grid_reg = 3'd1;
  logic [23:0] zbuf [int];
  tfz_pkg::tfz_out_t pending_px[$];
  int hot_px [8];
  int hot_py [8];

  triangle_fragment_zbuffer_msaa_unit #(
    .SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H), .MAX_SAMPLES_PER_AXIS(MAX_N)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                      longint qx, longint qy);
    return (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
  endfunction

  // returns 1 when the fragment passes the depth test; updates the store
  function automatic bit shade_fragment(input tfz_pkg::tfz_in_t f,
                                        output tfz_pkg::tfz_out_t r);
    longint vx [3];
    longint vy [3];
    logic [127:0] vz [3];
    logic [127:0] w0, w1, w2, num, den, z;
    longint s2, sx, sy, e0, e1, e2;
    logic [23:0] best, cur;
    int n, cnt, addr, nn, cr, cg, cb;
    r = '0;
    n = int'(grid_reg);
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    s2 = 2 * n;
    vx[0] = longint'(f.vert0_x) * s2; vy[0] = longint'(f.vert0_y) * s2;
    vx[1] = longint'(f.vert1_x) * s2; vy[1] = longint'(f.vert1_y) * s2;
    vx[2] = longint'(f.vert2_x) * s2; vy[2] = longint'(f.vert2_y) * s2;
    vz[0] = f.vert0_depth; vz[1] = f.vert1_depth; vz[2] = f.vert2_depth;
    best = tfz_pkg::FAR_DEPTH;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        sx = 16 * (s2 * longint'(f.pixel_x) + 2 * i + 1);
        sy = 16 * (s2 * longint'(f.pixel_y) + 2 * j + 1);
        e0 = edge_val(vx[0], vy[0], vx[1], vy[1], sx, sy);
        e1 = edge_val(vx[1], vy[1], vx[2], vy[2], sx, sy);
        e2 = edge_val(vx[2], vy[2], vx[0], vy[0], sx, sy);
        if ((e0 > 0 && e1 > 0 && e2 > 0) || (e0 < 0 && e1 < 0 && e2 < 0)) begin
          w0 = (e1 < 0) ? -e1 : e1;
          w1 = (e2 < 0) ? -e2 : e2;
          w2 = (e0 < 0) ? -e0 : e0;
          num = w0 * vz[0] + w1 * vz[1] + w2 * vz[2];
          den = w0 + w1 + w2;
          z = num / den;
          if (z > tfz_pkg::FAR_DEPTH) z = tfz_pkg::FAR_DEPTH;
          if (z[23:0] < best) best = z[23:0];
          cnt++;
        end
      end
    end
    if (cnt == 0) return 1'b0;
    addr = (SCR_H - 1 - int'(f.pixel_y)) * SCR_W + int'(f.pixel_x);
    cur = zbuf.exists(addr) ? zbuf[addr] : tfz_pkg::FAR_DEPTH;
    if (best >= cur) return 1'b0;
    zbuf[addr] = best;
    nn = n * n;
    cr = int'(f.tri_color[23:16]) * cnt / nn;
    cg = int'(f.tri_color[15:8]) * cnt / nn;
    cb = int'(f.tri_color[7:0]) * cnt / nn;
    r.frame_address = addr[19:0];
    r.pixel_color = {cr[7:0], cg[7:0], cb[7:0]};
    r.pixel_depth = best;
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    tfz_pkg::tfz_out_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        report($sformatf("unexpected result addr %0h", out_data.frame_address));
      end else begin
        exp_px = pending_px.pop_front();
        if (out_data.frame_address !== exp_px.frame_address)
          report($sformatf("frame_address %0h want %0h",
                           out_data.frame_address, exp_px.frame_address));
        if (out_data.pixel_color !== exp_px.pixel_color)
          report($sformatf("pixel_color %0h want %0h",
                           out_data.pixel_color, exp_px.pixel_color));
        if (out_data.pixel_depth !== exp_px.pixel_depth)
          report($sformatf("pixel_depth %0h want %0h",
                           out_data.pixel_depth, exp_px.pixel_depth));
      end
    end
  end

  // receiver idling
  always @(negedge clk) begin
    out_stall <= hold_out || (idle_on && $urandom_range(0, 99) < 9);
  end

  task automatic send_fragment(input tfz_pkg::tfz_in_t f);
    tfz_pkg::tfz_out_t px;
    if (idle_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (in_stall);
    if (shade_fragment(f, px)) pending_px.push_back(px);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    end_burst();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [2:0] val);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    grid_reg = val;
  endtask

  function automatic tfz_pkg::tfz_in_t make_tri(int x0, int y0, int z0, int x1, int y1,
                                                int z1, int x2, int y2, int z2, int col,
                                                int px, int py);
    tfz_pkg::tfz_in_t f;
    f.vert0_x = x0[15:0]; f.vert0_y = y0[15:0]; f.vert0_depth = z0[23:0];
    f.vert1_x = x1[15:0]; f.vert1_y = y1[15:0]; f.vert1_depth = z1[23:0];
    f.vert2_x = x2[15:0]; f.vert2_y = y2[15:0]; f.vert2_depth = z2[23:0];
    f.tri_color = col[23:0];
    f.pixel_x = px[9:0];
    f.pixel_y = py[9:0];
    return f;
  endfunction

  // mostly triangles around a pixel, some pure noise
  function automatic tfz_pkg::tfz_in_t random_fragment();
    tfz_pkg::tfz_in_t f;
    logic [223:0] noise;
    int px, py, cx, cy, spread, k;
    if ($urandom_range(0, 99) < 12) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      f = noise[$bits(tfz_pkg::tfz_in_t)-1:0];
      return f;
    end
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 99) < 60) begin
      px = hot_px[k]; py = hot_py[k];
    end else begin
      px = $urandom_range(0, SCR_W - 1); py = $urandom_range(0, SCR_H - 1);
    end
    cx = px * 16 + 8;
    cy = py * 16 + 8;
    spread = ($urandom_range(0, 9) < 7) ? 48 : 400;
    f = make_tri(cx + $urandom_range(0, 2 * spread) - spread,
                 cy + $urandom_range(0, 2 * spread) - spread, $urandom_range(0, 24'hFFFFFF),
                 cx + $urandom_range(0, 2 * spread) - spread,
                 cy + $urandom_range(0, 2 * spread) - spread, $urandom_range(0, 24'hFFFFFF),
                 cx + $urandom_range(0, 2 * spread) - spread,
                 cy + $urandom_range(0, 2 * spread) - spread, $urandom_range(0, 24'hFFFFFF),
                 $urandom_range(0, 24'hFFFFFF), px, py);
    return f;
  endfunction

  task automatic test_directed();
    // both windings around pixel (0,0) and (1,0)
    send_fragment(make_tri(-20, -20, 300, 40, -20, 200, 8, 40, 100, 24'hFFFFFF, 0, 0));
    send_fragment(make_tri(8, 40, 100, 60, -20, 200, -4, -20, 300, 24'hFFFFFF, 1, 0));
    // same fragment again: equal depth, no write
    send_fragment(make_tri(-20, -20, 300, 40, -20, 200, 8, 40, 100, 24'hFFFFFF, 0, 0));
    // nearer at the same pixel, zero depth
    send_fragment(make_tri(-20, -20, 0, 40, -20, 0, 8, 40, 0, 24'h123456, 0, 0));
    // collinear vertices
    send_fragment(make_tri(0, 0, 10, 16, 16, 10, 32, 32, 10, 24'hFFFFFF, 0, 0));
    // triangle beside the pixel
    send_fragment(make_tri(100, 100, 5, 140, 100, 5, 120, 140, 5, 24'hFFFFFF, 2, 2));
    // top right corner, farthest depth never passes
    send_fragment(make_tri(16340, 16340, 24'hFFFFFF, 16400, 16340, 24'hFFFFFF,
                           16370, 16400, 24'hFFFFFF, 24'hFFFFFF, 1023, 1023));
    send_fragment(make_tri(16340, 16340, 24'hFFFFFE, 16400, 16340, 24'hFFFFFE,
                           16370, 16400, 24'hFFFFFE, 24'h000000, 1023, 1023));
    // extreme coordinates, huge triangle
    send_fragment(make_tri(-32768, -32768, 24'hFFFFFF, 32767, -32768, 0,
                           -32768, 32767, 24'h800000, 24'hA5C30F, 500, 500));
    send_fragment(make_tri(32767, 32767, 7, -32768, 32767, 24'hFFFFFF,
                           32767, -32768, 3, 24'h5A3CF0, 700, 300));
    send_fragment(make_tri(-32768, -32768, 0, 32767, -32768, 0,
                           -32768, 32767, 0, 24'hFFFFFF, 1023, 0));
    // edge through the sample point: strict test rejects it
    send_fragment(make_tri(8, 8, 1, 100, 8, 1, 8, 100, 1, 24'hFFFFFF, 3, 0));
    drain();
  endtask

  task automatic test_random(input int items, input logic [2:0] grid, input bit idle);
    set_grid(grid);
    idle_on = idle;
    repeat (items) send_fragment(random_fragment());
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure(input logic [2:0] grid);
    set_grid(grid);
    hold_out = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
    join_none
    repeat (40) send_fragment(random_fragment());
  endtask

  initial begin
    for (int k = 0; k < 8; k++) begin
      hot_px[k] = $urandom_range(0, SCR_W - 1);
      hot_py[k] = $urandom_range(0, SCR_H - 1);
    end
    hot_px[0] = 0; hot_py[0] = 0;
    hot_px[1] = SCR_W - 1; hot_py[1] = SCR_H - 1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(60, 3'd1, 1'b1);
    test_random(60, 3'd4, 1'b1);
    test_random(50, 3'd0, 1'b1);
    test_random(50, 3'd7, 1'b0);
    test_backpressure(3'd2);
    test_random(60, 3'd3, 1'b1);
    test_random(40, 3'd5, 1'b1);
    test_random(40, 3'd6, 1'b1);
    test_random(50, 3'd1, 1'b1);
    drain();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/tfz_pkg.sv
rtl/tfz_ram.sv
rtl/tfz_div.sv
rtl/tfz_fifo.sv
rtl/tfz_front.sv
rtl/tfz_back.sv
rtl/triangle_fragment_zbuffer_msaa_unit.sv
bench/tb_triangle_fragment_zbuffer_msaa_unit.sv
